/* rtl/core/idwq_pkg.sv */
// Shared types, constants and reset tables for the ID whitelist with usage quota.
// Used by idwq_ctrl, idwq_datapath and id_whitelist_with_usage_quota_core.
`default_nettype none

package idwq_pkg;

  localparam int ENTRIES  = 10;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LIVE_W   = $clog2(ENTRIES + 1);
  localparam int ID_W     = 32;
  localparam int AMT_W    = 30;
  localparam int CNT_W    = 31;
  localparam int SLOT_W   = 4;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] QUOTA_RESET = 31'd1000000000;

  // register index taken from the word address bit
  localparam logic REG_QUOTA = 1'b0;

  localparam int INIT_NUM = 10;
  localparam logic [ID_W-1:0] INIT_IDS [INIT_NUM] = '{
    32'ha3e980c4, 32'hcd23e300, 32'h0034a197, 32'h31aa9872, 32'h19840335,
    32'h214a9845, 32'hcdef1239, 32'hb8c0349a, 32'h9e802246, 32'h239f9234
  };
  localparam logic [CNT_W-1:0] INIT_COUNTS [INIT_NUM] = '{
    31'd10, 31'd5, 31'd23, 31'd54, 31'd2, 31'd7, 31'd113, 31'd104, 31'd1, 31'd0
  };

  typedef struct packed {
    logic [ID_W-1:0]  lookup_id;
    logic [AMT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              removed;
    logic [CNT_W-1:0]  new_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;      // latch request, restart scan
    logic step;      // advance scan index
    logic capture;   // matched: record slot, write saturated count
    logic check;     // record quota verdict
    logic shift;     // move entry idx+1 down to idx
    logic dec_live;  // one entry fewer
    logic out_load;  // result into output register
  } cmd_t;

  typedef struct packed {
    logic empty;       // no live entries
    logic match;       // entry at scan index matches
    logic scan_last;   // idx + 1 >= live
    logic shift_last;  // idx + 2 >= live
    logic over_quota;  // captured count above limit
    logic out_busy;    // result waiting and receiver stalled
  } sts_t;

  function automatic logic [ID_W-1:0] init_id(input int i);
    logic [ID_W-1:0] v;
    v = '0;
    if (i < INIT_NUM) v = INIT_IDS[i];
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] init_count(input int i);
    logic [CNT_W-1:0] v;
    v = '0;
    if (i < INIT_NUM) v = INIT_COUNTS[i];
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/idwq_ctrl.sv */
// Sequencer for lookup, count update and table compaction.
// Depends on idwq_pkg for state, command and status types.
`default_nettype none

module idwq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  idwq_pkg::sts_t      sts,
  output idwq_pkg::cmd_t      cmd
);

  idwq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idwq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      idwq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.empty ? idwq_pkg::ST_DONE : idwq_pkg::ST_SCAN;
        end
      end
      idwq_pkg::ST_SCAN: begin
        if (sts.match) begin
          cmd.capture = 1'b1;
          state_next  = idwq_pkg::ST_CHECK;
        end else if (sts.scan_last) begin
          state_next = idwq_pkg::ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      idwq_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (!sts.over_quota) begin
          state_next = idwq_pkg::ST_DONE;
        end else if (sts.scan_last) begin
          cmd.dec_live = 1'b1;
          state_next   = idwq_pkg::ST_DONE;
        end else begin
          state_next = idwq_pkg::ST_SHIFT;
        end
      end
      idwq_pkg::ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_last) begin
          cmd.dec_live = 1'b1;
          state_next   = idwq_pkg::ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      idwq_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = idwq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = idwq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/idwq_datapath.sv */
// Whitelist tables, scan index, saturating adder and output register.
// Depends on idwq_pkg for widths, reset tables, command and status types.
`default_nettype none

module idwq_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  idwq_pkg::cmd_t                       cmd,
  output idwq_pkg::sts_t                       sts,
  input  idwq_pkg::req_t                       in_data,
  input  wire logic [idwq_pkg::CNT_W-1:0]      quota,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output idwq_pkg::rsp_t                       out_data
);

  localparam int XW = idwq_pkg::LIVE_W + 1;

  logic [idwq_pkg::ID_W-1:0]   id_tab  [idwq_pkg::ENTRIES];
  logic [idwq_pkg::CNT_W-1:0]  cnt_tab [idwq_pkg::ENTRIES];
  logic [idwq_pkg::LIVE_W-1:0] live;
  logic [idwq_pkg::IDX_W-1:0]  idx;
  logic [idwq_pkg::IDX_W-1:0]  pos;
  logic [idwq_pkg::IDX_W-1:0]  rd_addr;
  logic [idwq_pkg::ID_W-1:0]   req_id;
  logic [idwq_pkg::AMT_W-1:0]  amt;
  logic [idwq_pkg::CNT_W-1:0]  cnt;
  logic                        hit;
  logic                        gone;
  logic                        shifting;

  logic [XW-1:0]               idx_p1;
  logic [XW-1:0]               idx_p2;
  logic [XW-1:0]               live_x;
  logic [idwq_pkg::CNT_W:0]    sum;
  logic [idwq_pkg::CNT_W-1:0]  cnt_sat;
  logic [idwq_pkg::ID_W-1:0]   rd_id;
  logic [idwq_pkg::CNT_W-1:0]  rd_cnt;

  assign idx_p1  = XW'(idx) + XW'(1);
  assign idx_p2  = XW'(idx) + XW'(2);
  assign live_x  = XW'(live);
  // single read port: entry above idx while compacting, else idx
  assign rd_addr = shifting ? idwq_pkg::IDX_W'(idx_p1) : idx;
  assign rd_id   = id_tab[rd_addr];
  assign rd_cnt  = cnt_tab[rd_addr];

  assign sum     = {1'b0, rd_cnt} + (idwq_pkg::CNT_W + 1)'(amt);
  assign cnt_sat = sum[idwq_pkg::CNT_W] ? idwq_pkg::COUNT_MAX : sum[idwq_pkg::CNT_W-1:0];

  always_comb begin
    sts            = '0;
    sts.empty      = (live == '0);
    sts.match      = (rd_id == req_id);
    sts.scan_last  = (idx_p1 >= live_x);
    sts.shift_last = (idx_p2 >= live_x);
    sts.over_quota = (cnt > quota);
    sts.out_busy   = out_valid && out_stall;
  end

  // tables reset to the built-in list; one write address per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < idwq_pkg::ENTRIES; i++) begin
        id_tab[i]  <= idwq_pkg::init_id(i);
        cnt_tab[i] <= idwq_pkg::init_count(i);
      end
      live <= idwq_pkg::LIVE_W'(idwq_pkg::ENTRIES);
    end else begin
      if (cmd.capture) begin
        cnt_tab[idx] <= cnt_sat;
      end else if (cmd.shift) begin
        id_tab[idx]  <= rd_id;
        cnt_tab[idx] <= rd_cnt;
      end
      if (cmd.dec_live) live <= live - idwq_pkg::LIVE_W'(1);
    end
  end

  // shifting follows the quota verdict, so the read address never waits on cmd
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      hit      <= 1'b0;
      gone     <= 1'b0;
      shifting <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx      <= '0;
        hit      <= 1'b0;
        gone     <= 1'b0;
        shifting <= 1'b0;
      end else if (cmd.step) begin
        idx <= idx + idwq_pkg::IDX_W'(1);
      end
      if (cmd.capture) hit <= 1'b1;
      if (cmd.check) begin
        gone     <= sts.over_quota;
        shifting <= sts.over_quota;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_id <= in_data.lookup_id;
      amt    <= in_data.amount;
    end
    if (cmd.capture) begin
      pos <= idx;
      cnt <= cnt_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.hit       <= hit;
      out_data.slot      <= hit ? idwq_pkg::SLOT_W'(XW'(pos)) : '0;
      out_data.removed   <= hit && gone;
      out_data.new_count <= hit ? cnt : '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/id_whitelist_with_usage_quota_core.sv */
// Top level of the ID whitelist with usage quota: APB quota register,
// controller and datapath. Depends on idwq_pkg, idwq_ctrl, idwq_datapath.
`default_nettype none

// Usage
//   Request channel (in_valid / in_stall / in_data): identifier and usage
//   amount. A transaction completes on a rising edge with in_valid high and
//   in_stall low. One request is handled at a time; in_stall is high from
//   acceptance until the result has been handed to the output register.
//   Result channel (out_valid / out_stall / out_data): exactly one result
//   per request - hit, slot, removed, new_count. Miss gives zero fields.
//   Steps per request: accept, scan from slot 0 up to the match (over all
//   live entries on a miss), quota check on a hit, shift steps that close
//   the gap when a hit is over quota, then the result; the scan and the
//   compaction share the single table read port.
//   The output register lets the next request be accepted while a result
//   waits; a stalled result holds and the following one waits in the
//   final state until the register frees.
//   Reset (rst, synchronous): the table returns to the built-in ten entries,
//   all live, and quota_limit to 1000000000. No clearing pass is needed.
//   APB: quota_limit at byte addresses 0 to 3 (paddr[2] low); addresses 4 to 7
//   read zero and ignore writes. Write only while the block is idle.

module id_whitelist_with_usage_quota_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  idwq_pkg::req_t                     in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output idwq_pkg::rsp_t                     out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [idwq_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [idwq_pkg::PDATA_W-1:0]  pwdata,
  output logic [idwq_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  logic [idwq_pkg::CNT_W-1:0] quota_limit;
  idwq_pkg::cmd_t             cmd;
  idwq_pkg::sts_t             sts;
  logic                       reg_sel;

  // word index: byte address / 4
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quota_limit <= idwq_pkg::QUOTA_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == idwq_pkg::REG_QUOTA) begin
      quota_limit <= pwdata[idwq_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == idwq_pkg::REG_QUOTA) prdata = idwq_pkg::PDATA_W'(quota_limit);
  end

  idwq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  idwq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .quota     (quota_limit),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
